FILE: rtl/futex_wait_queue_engine_top_defines.svh
// Assertion macros shared by the futex queue RTL.
`ifndef FUTEX_WAIT_QUEUE_ENGINE_TOP_DEFINES_SVH
`define FUTEX_WAIT_QUEUE_ENGINE_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FWQ_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define FWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/fwqe_pkg.sv
// Shared status codes and widths for the futex queue engine.
package fwqe_pkg;
   localparam int AddrWidth = 48;
   localparam int ValueWidth = 32;
   localparam int ThreadWidth = 16;
   localparam int CountWidth = 16;
   localparam int StatusWidth = 3;
   localparam int SoFarWidth = 5;
   localparam int MaxWoken = 16;

   localparam logic [1:0] ACT_WAIT = 2'd0;
   localparam logic [1:0] ACT_WAKE = 2'd1;

   localparam logic [2:0] ST_BLOCKED = 3'd0;
   localparam logic [2:0] ST_MISMATCH = 3'd1;
   localparam logic [2:0] ST_WOKE = 3'd2;
   localparam logic [2:0] ST_NONE = 3'd3;
   localparam logic [2:0] ST_UNSUPP = 3'd4;
   localparam logic [2:0] ST_FULL = 3'd5;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [ThreadWidth-1:0] woken_thread;
      logic [SoFarWidth-1:0]  woken_so_far;
      logic                   last;
   } rsp_type;
endpackage

FILE: rtl/futex_wait_queue_engine_top.sv
// Futex wait/wake queue engine: key table search and waiter lists in memory.
//
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tdata: action, address, cur, cmp, thread, count
// rsp      out  rsp_tvalid/tready    tdata: status, woken_thread, woken_so_far; tlast
//
// A wait runs the key search, a decide state and the list update (S_WLINK then
// S_WDATA), then stays in emit until the response is taken.
// A wake runs the key search, a decide state and a head read state, then for
// each woken thread a memory read of the waiter then the write back; the waiter
// memory read port sets this order.
// Synchronous reset clears the key valid bits and the free list control; the
// link memory is swept after reset before requests are taken.
// A stalled response holds the engine in its emit state; requests then wait.
`include "futex_wait_queue_engine_top_defines.svh"
module futex_wait_queue_engine_top #(
   parameter int KEYS = 8,
   parameter int WAITERS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] action, [49:2] address, [81:50] current_value, [113:82] compare_value,
   // [129:114] thread_id, [145:130] wake_count, [151:146] zero
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] status, [18:3] woken_thread, [23:19] woken_so_far
   output logic [23:0]  rsp_tdata,
   output logic         rsp_tlast
);
   import fwqe_pkg::*;

   localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int WW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
   localparam int FCW = $clog2(WAITERS + 1);
   localparam int KCW = $clog2(KEYS + 1);

   localparam logic [3:0] S_SWEEP = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_SEARCH = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_WLINK = 4'd4;
   localparam logic [3:0] S_RDW = 4'd5;
   localparam logic [3:0] S_WDATA = 4'd6;
   localparam logic [3:0] S_EMIT = 4'd7;
   localparam logic [3:0] S_WEMIT = 4'd8;

   // memories
   logic [AddrWidth-1:0]   key_mem [KEYS];
   logic [WW-1:0]          head_mem [KEYS];
   logic [WW-1:0]          tail_mem [KEYS];
   logic [ThreadWidth-1:0] thr_mem [WAITERS];
   logic [WW-1:0]          link_mem [WAITERS];

   logic [KEYS-1:0]        in_use_ff, in_use_in;
   logic [3:0]             state_ff, state_in;
   logic [WW-1:0]          free_head_ff, free_head_in;
   logic [FCW-1:0]         free_count_ff, free_count_in;
   logic [KCW-1:0]         kidx_ff, kidx_in;
   logic                   found_ff, found_in;
   logic [KW-1:0]          key_ff, key_in;
   logic [1:0]             act_ff;
   logic [AddrWidth-1:0]   addr_ff;
   logic                   match_ff;
   logic [ThreadWidth-1:0] tid_ff;
   logic [SoFarWidth-1:0]  want_ff;
   logic [SoFarWidth-1:0]  n_ff, n_in;
   logic [WW-1:0]          head_ff, head_in, tail_ff, tail_in;
   logic [WW-1:0]          w_ff, w_in;
   logic [WW-1:0]          sweep_ff;
   rsp_type                rsp_ff, rsp_in;

   // registered memory reads
   logic [AddrWidth-1:0]   key_rd_ff;
   logic [WW-1:0]          link_rd_ff;
   logic [ThreadWidth-1:0] thr_rd_ff;
   logic [WW-1:0]          hd_rd_ff, tl_rd_ff;

   logic [KW-1:0]          key_raddr;
   logic [WW-1:0]          wait_raddr;
   logic                   link_we, thr_we, ht_we, key_we;
   logic [WW-1:0]          link_waddr, link_wdata, hd_wdata, tl_wdata;
   logic [KW-1:0]          first_free;
   logic                   any_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tdata = {rsp_ff.woken_so_far, rsp_ff.woken_thread, rsp_ff.status};
   assign rsp_tlast = rsp_ff.last;

   // lowest free key slot
   always_comb begin
      first_free = '0;
      any_free = 1'b0;
      for (int i = KEYS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            first_free = KW'(i);
            any_free = 1'b1;
         end
      end
   end

   assign key_raddr = kidx_ff[KW-1:0];

   // memory ports
   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[key_raddr];
      hd_rd_ff <= head_mem[key_ff];
      tl_rd_ff <= tail_mem[key_ff];
      link_rd_ff <= link_mem[wait_raddr];
      thr_rd_ff <= thr_mem[wait_raddr];
      if (key_we) key_mem[key_ff] <= addr_ff;
      if (ht_we) begin
         head_mem[key_ff] <= hd_wdata;
         tail_mem[key_ff] <= tl_wdata;
      end
      if (thr_we) thr_mem[w_ff] <= tid_ff;
      if (link_we) link_mem[link_waddr] <= link_wdata;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff <= req_tdata[1:0];
         addr_ff <= req_tdata[49:2];
         match_ff <= (req_tdata[81:50] == req_tdata[113:82]);
         tid_ff <= req_tdata[129:114];
         want_ff <= (req_tdata[145:130] > CountWidth'(MaxWoken)) ?
            SoFarWidth'(MaxWoken) : req_tdata[130 +: SoFarWidth];
      end
   end

   // control sequencer
   always_comb begin
      state_in = state_ff;
      in_use_in = in_use_ff;
      free_head_in = free_head_ff;
      free_count_in = free_count_ff;
      kidx_in = kidx_ff;
      found_in = found_ff;
      key_in = key_ff;
      n_in = n_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      w_in = w_ff;
      rsp_in = rsp_ff;
      wait_raddr = free_head_ff;
      link_we = 1'b0;
      thr_we = 1'b0;
      ht_we = 1'b0;
      key_we = 1'b0;
      link_waddr = sweep_ff;
      link_wdata = (sweep_ff == WW'(WAITERS - 1)) ? '0 : WW'(sweep_ff + 1'b1);
      hd_wdata = head_ff;
      tl_wdata = tail_ff;
      case (state_ff)
         S_SWEEP: begin
            link_we = 1'b1;
            if (sweep_ff == WW'(WAITERS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            kidx_in = '0;
            found_in = 1'b0;
            n_in = '0;
            if (req_tvalid) state_in = S_SEARCH;
         end
         S_SEARCH: begin
            // one key read per cycle; compare the previous read
            if (kidx_ff != '0) begin
               if (in_use_ff[KW'(kidx_ff - 1'b1)] && key_rd_ff == addr_ff && !found_in) begin
                  found_in = 1'b1;
                  key_in = KW'(kidx_ff - 1'b1);
               end
            end
            if (kidx_ff == KCW'(KEYS)) state_in = S_DECIDE;
            else kidx_in = kidx_ff + 1'b1;
         end
         S_DECIDE: begin
            rsp_in = '{status: ST_UNSUPP, woken_thread: '0, woken_so_far: '0, last: 1'b1};
            state_in = S_EMIT;
            if (act_ff == ACT_WAIT) begin
               if (!match_ff) rsp_in.status = ST_MISMATCH;
               else if (free_count_ff == '0) rsp_in.status = ST_FULL;
               else if (!found_ff && !any_free) rsp_in.status = ST_FULL;
               else begin
                  if (!found_ff) key_in = first_free;
                  w_in = free_head_ff;
                  state_in = S_WLINK;
               end
            end else if (act_ff == ACT_WAKE) begin
               if (!found_ff || want_ff == '0) rsp_in.status = ST_NONE;
               else state_in = S_RDW;
            end
         end
         S_WLINK: begin
            // link_rd_ff / hd,tl reads now valid
            free_head_in = link_rd_ff;
            free_count_in = free_count_ff - 1'b1;
            thr_we = 1'b1;
            link_we = 1'b1;
            link_waddr = w_ff;
            link_wdata = '0;
            state_in = S_WDATA;
            if (!in_use_ff[key_ff]) begin
               in_use_in[key_ff] = 1'b1;
               key_we = 1'b1;
               head_in = w_ff;
            end else begin
               head_in = hd_rd_ff;
            end
            tail_in = w_ff;
         end
         S_WDATA: begin
            ht_we = 1'b1;
            if (in_use_ff[key_ff] && head_ff != w_ff) begin
               link_we = 1'b1;
               link_waddr = tl_rd_ff;
               link_wdata = w_ff;
            end
            rsp_in = '{status: ST_BLOCKED, woken_thread: '0, woken_so_far: '0, last: 1'b1};
            state_in = S_EMIT;
         end
         S_RDW: begin
            // head/tail read valid; read waiter at head next
            head_in = hd_rd_ff;
            tail_in = tl_rd_ff;
            wait_raddr = hd_rd_ff;
            state_in = S_WEMIT;
         end
         S_WEMIT: begin
            n_in = n_ff + 1'b1;
            rsp_in = '{status: ST_WOKE, woken_thread: thr_rd_ff,
                       woken_so_far: n_ff + 1'b1, last: 1'b0};
            link_we = 1'b1;
            link_waddr = head_ff;
            link_wdata = free_head_ff;
            free_head_in = head_ff;
            free_count_in = free_count_ff + 1'b1;
            if (head_ff == tail_ff) begin
               in_use_in[key_ff] = 1'b0;
               rsp_in.last = 1'b1;
            end else begin
               head_in = link_rd_ff;
               ht_we = 1'b1;
               hd_wdata = link_rd_ff;
               tl_wdata = tail_ff;
               if (n_ff + 1'b1 == want_ff) rsp_in.last = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            wait_raddr = head_ff;
            if (rsp_tready) begin
               if (rsp_ff.last) state_in = S_IDLE;
               else state_in = S_WEMIT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         in_use_ff <= '0;
         free_head_ff <= '0;
         free_count_ff <= FCW'(WAITERS);
         sweep_ff <= '0;
         kidx_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         in_use_ff <= in_use_in;
         free_head_ff <= free_head_in;
         free_count_ff <= free_count_in;
         sweep_ff <= (state_ff == S_SWEEP) ? WW'(sweep_ff + 1'b1) : sweep_ff;
         kidx_ff <= kidx_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      n_ff <= n_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      w_ff <= w_in;
      rsp_ff <= rsp_in;
   end

   `FWQ_ASSERT_IMPL(a_free_bound, 1'b1, free_count_ff <= FCW'(WAITERS), "free count overflow")
   `FWQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response dropped")
   `FWQ_ASSERT_IMPL(a_no_req_busy, rsp_tvalid, !req_tready, "request taken while emitting")
   `FWQ_ASSERT_IMPL(a_so_far, rsp_tvalid && rsp_ff.status == ST_WOKE, rsp_ff.woken_so_far != '0, "woken count zero")
endmodule
